>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the alarm latch manager.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ALM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ALM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/alm_pkg.sv
package alm_pkg;

	// Command codes carried in the command field.
	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_PREPARE = 2'd1,
		CMD_PROCESS = 2'd2,
		CMD_NOP     = 2'd3
	} alm_cmd_t;

	// Reset policy codes.
	localparam logic [2:0] POL_MANUAL    = 3'd0;
	localparam logic [2:0] POL_AUTO      = 3'd1;
	localparam logic [2:0] POL_AUX       = 3'd2;
	localparam logic [2:0] POL_AUTO_COND = 3'd3;
	localparam logic [2:0] POL_AUTO_PROV = 3'd4;
	localparam logic [2:0] POL_AUTO_PRIO = 3'd5;

	// Severity categories that the logic refers to.
	localparam logic [1:0] SEV_ALARM   = 2'd0;
	localparam logic [1:0] SEV_ANOMALY = 2'd1;
	localparam logic [1:0] SEV_INFO    = 2'd3;

	// One input item.
	typedef struct packed {
		logic [1:0]  command;
		logic        reset_level;
		logic        aux_level;
		logic        selective_level;
		logic [7:0]  selective_code;
		logic [7:0]  signal_code;
		logic [1:0]  severity;
		logic [2:0]  reset_policy;
		logic        activation;
		logic        auto_condition;
		logic [15:0] action_bits;
	} alm_item_t;

	// One result item.
	typedef struct packed {
		logic        latched;
		logic [15:0] action_mask;
		logic [1:0]  worst_severity;
		logic        reset_allowed;
		logic        aux_allowed;
		logic        fault;
	} alm_result_t;

	// Write controls for the latch bank.
	typedef struct packed {
		logic clear;
		logic en;
		logic data;
	} latch_wr_t;

endpackage

>>> rtl/core/alarm_latch_manager.sv
// Pipeline: an item is held in the input register, then in the result register;
// a result stall holds both. The latch bank is read and written in the same cycle.
// Throughput: one item per cycle while the result side is not stalled.
// Reset: arst_n clears all latch flops, edge memories, accumulators and flags
// at once; no clearing pass follows, so an item can be taken right after reset.
module alarm_latch_manager #(
	parameter int LIST_SIZE = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  alm_pkg::alm_item_t   item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output alm_pkg::alm_result_t result
);

	logic               s1_valid_q;
	alm_pkg::alm_item_t item_s1;
	logic               result_valid_q;
	logic               advance;
	logic               fire;

	// The result register can take a new item when empty or being emptied.
	assign advance    = !result_valid_q || !result_stall;
	assign fire       = s1_valid_q && advance;
	assign item_stall = s1_valid_q && !advance;

	// Input register valid and result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (!item_stall) begin
				s1_valid_q <= item_valid;
			end
			if (advance) begin
				result_valid_q <= s1_valid_q;
			end
		end
	end

	// Input payload is captured on each transfer.
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	alm_eval #(
		.LIST_SIZE(LIST_SIZE)
	) u_eval (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (item_s1),
		.result(result)
	);

	assign result_valid = result_valid_q;

endmodule

>>> rtl/core/alm_latch_bank.sv
module alm_latch_bank #(
	parameter int LIST_SIZE = 64,
	parameter int IDX_W     = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  alm_pkg::latch_wr_t wr,
	input  logic [IDX_W-1:0]  wr_idx,
	input  logic [IDX_W-1:0]  rd_idx,
	output logic              rd_data
);

	logic [LIST_SIZE-1:0] bits_q;

	// One latch flop per code; clear-all drops every latch at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
		end else if (wr.clear) begin
			bits_q <= '0;
		end else if (wr.en) begin
			bits_q[wr_idx] <= wr.data;
		end
	end

	// Read port for the code being evaluated.
	assign rd_data = bits_q[rd_idx];

endmodule

>>> rtl/core/alm_eval.sv
`include "assert_macros.svh"

module alm_eval #(
	parameter int LIST_SIZE = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  alm_pkg::alm_item_t   item,
	output alm_pkg::alm_result_t result
);

	localparam int IDX_W = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;

	// Edge memories, accumulators and flags.
	logic        reset_prev_q, aux_prev_q, sel_prev_q;
	logic        reset_edge_q, aux_edge_q, sel_edge_q;
	logic [15:0] mask_acc_q;
	logic [1:0]  sev_acc_q;
	logic        reset_en_q, aux_en_q, fault_q;

	logic        reset_prev_d, aux_prev_d, sel_prev_d;
	logic        reset_edge_d, aux_edge_d, sel_edge_d;
	logic [15:0] mask_acc_d;
	logic [1:0]  sev_acc_d;
	logic        reset_en_d, aux_en_d, fault_d;

	alm_pkg::alm_result_t result_q;
	alm_pkg::latch_wr_t   lat_wr;
	logic [IDX_W-1:0]     idx;
	logic                 code_ok;
	logic                 stored;
	logic                 cur;
	logic                 manual;
	logic                 auto_pol;
	logic                 may_clear;
	logic                 new_latch;
	logic                 out_latched;

	// Code range check and latch index.
	assign code_ok = (item.signal_code != 8'd0) &&
		({1'b0, item.signal_code} <= 9'(LIST_SIZE));
	assign idx = IDX_W'(item.signal_code - 8'd1);

	alm_latch_bank #(
		.LIST_SIZE(LIST_SIZE),
		.IDX_W    (IDX_W)
	) u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (lat_wr),
		.wr_idx (idx),
		.rd_idx (idx),
		.rd_data(stored)
	);

	assign cur = code_ok && stored;

	// Latch decision for a process command.
	assign manual   = (item.severity <= alm_pkg::SEV_ANOMALY) &&
		(item.reset_policy != alm_pkg::POL_AUTO);
	assign auto_pol = (item.reset_policy == alm_pkg::POL_AUTO_COND) ||
		(item.reset_policy == alm_pkg::POL_AUTO_PROV) ||
		(item.reset_policy == alm_pkg::POL_AUTO_PRIO);
	assign may_clear = !manual || reset_edge_q ||
		(aux_edge_q && (item.reset_policy == alm_pkg::POL_AUX)) ||
		(item.auto_condition && auto_pol) ||
		(sel_edge_q && (item.selective_code == item.signal_code));
	assign new_latch = item.activation || (cur && !may_clear);

	// Next state for the item in the input register.
	always_comb begin
		reset_prev_d = reset_prev_q;
		aux_prev_d   = aux_prev_q;
		sel_prev_d   = sel_prev_q;
		reset_edge_d = reset_edge_q;
		aux_edge_d   = aux_edge_q;
		sel_edge_d   = sel_edge_q;
		mask_acc_d   = mask_acc_q;
		sev_acc_d    = sev_acc_q;
		reset_en_d   = reset_en_q;
		aux_en_d     = aux_en_q;
		fault_d      = fault_q;
		lat_wr       = '0;
		out_latched  = cur;
		unique case (item.command)
			alm_pkg::CMD_CLEAR: begin
				lat_wr.clear = fire;
				reset_prev_d = 1'b0;
				aux_prev_d   = 1'b0;
				sel_prev_d   = 1'b0;
				mask_acc_d   = '0;
				sev_acc_d    = alm_pkg::SEV_INFO;
				reset_en_d   = 1'b0;
				aux_en_d     = 1'b0;
				out_latched  = 1'b0;
			end
			alm_pkg::CMD_PREPARE: begin
				reset_edge_d = item.reset_level && !reset_prev_q;
				aux_edge_d   = item.aux_level && !aux_prev_q;
				sel_edge_d   = item.selective_level && !sel_prev_q;
				reset_prev_d = item.reset_level;
				aux_prev_d   = item.aux_level;
				sel_prev_d   = item.selective_level;
				mask_acc_d   = '0;
				sev_acc_d    = alm_pkg::SEV_INFO;
				reset_en_d   = 1'b0;
				aux_en_d     = 1'b0;
			end
			alm_pkg::CMD_PROCESS: begin
				if (!code_ok) begin
					fault_d = 1'b1;
				end else begin
					lat_wr.en   = fire;
					lat_wr.data = new_latch;
					out_latched = new_latch;
					if (new_latch) begin
						mask_acc_d = mask_acc_q | item.action_bits;
						if (item.severity < sev_acc_q) begin
							sev_acc_d = item.severity;
						end
						if (!item.activation && manual) begin
							reset_en_d = 1'b1;
						end
						if (!item.activation &&
							(item.reset_policy == alm_pkg::POL_AUX)) begin
							aux_en_d = 1'b1;
						end
					end
				end
			end
			alm_pkg::CMD_NOP: begin
			end
			default: begin
			end
		endcase
	end

	// State registers advance once per transfer into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_prev_q <= 1'b0;
			aux_prev_q   <= 1'b0;
			sel_prev_q   <= 1'b0;
			reset_edge_q <= 1'b0;
			aux_edge_q   <= 1'b0;
			sel_edge_q   <= 1'b0;
			mask_acc_q   <= '0;
			sev_acc_q    <= alm_pkg::SEV_INFO;
			reset_en_q   <= 1'b0;
			aux_en_q     <= 1'b0;
			fault_q      <= 1'b0;
		end else if (fire) begin
			reset_prev_q <= reset_prev_d;
			aux_prev_q   <= aux_prev_d;
			sel_prev_q   <= sel_prev_d;
			reset_edge_q <= reset_edge_d;
			aux_edge_q   <= aux_edge_d;
			sel_edge_q   <= sel_edge_d;
			mask_acc_q   <= mask_acc_d;
			sev_acc_q    <= sev_acc_d;
			reset_en_q   <= reset_en_d;
			aux_en_q     <= aux_en_d;
			fault_q      <= fault_d;
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (fire) begin
			result_q.latched        <= out_latched;
			result_q.action_mask    <= mask_acc_d;
			result_q.worst_severity <= sev_acc_d;
			result_q.reset_allowed  <= reset_en_d;
			result_q.aux_allowed    <= aux_en_d;
			result_q.fault          <= fault_d;
		end
	end

	assign result = result_q;

	// The error flag never drops once set.
	`ALM_ASSERT_NEXT(a_fault_sticky, fault_q, fault_q, "fault flag dropped")

	// Clear-all restores the accumulators and enable flags.
	`ALM_ASSERT_NEXT(a_clear_acc,
		fire && (item.command == alm_pkg::CMD_CLEAR),
		(mask_acc_q == 16'd0) && (sev_acc_q == alm_pkg::SEV_INFO) &&
		!reset_en_q && !aux_en_q,
		"clear-all left accumulators set")

	// A manual-reset alarm can only be latched at alarm or anomaly severity.
	`ALM_ASSERT_NOW(a_reset_en_sev, reset_en_q, sev_acc_q <= alm_pkg::SEV_ANOMALY,
		"reset enable without severe latched alarm")

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int CODES = 64;
	localparam int STALL_MAX = 12;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 520;

	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_stall;
	alm_pkg::alm_item_t   item;
	logic                 result_valid;
	logic                 result_stall;
	alm_pkg::alm_result_t result;

	// Expected status words, one per accepted transfer, oldest first.
	alm_pkg::alm_result_t status_q[$];
	int failures = 0;
	int idle_cycles = 0;
	// When set, neither side inserts wait cycles.
	bit no_gaps = 1'b0;

	// Predicted block state.
	logic        latch_mem [CODES];
	logic        rst_prev = 1'b0;
	logic        aux_prev = 1'b0;
	logic        sel_prev = 1'b0;
	logic        rst_rise = 1'b0;
	logic        aux_rise = 1'b0;
	logic        sel_rise = 1'b0;
	logic [15:0] mask_or = '0;
	logic [1:0]  worst_sev = alm_pkg::SEV_INFO;
	logic        reset_ok = 1'b0;
	logic        aux_ok = 1'b0;
	logic        fault_flag = 1'b0;

	alarm_latch_manager dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Apply one command to the predicted state and return the status it shows.
	function automatic alm_pkg::alm_result_t advance_alarm_state(alm_pkg::alm_item_t it);
		logic                 code_ok;
		logic                 hold_for_reset;
		logic                 auto_policy;
		int                   slot;
		alm_pkg::alm_result_t st;
		code_ok = (it.signal_code >= 8'd1) && (it.signal_code <= CODES);
		slot = int'(it.signal_code) - 1;
		case (it.command)
			alm_pkg::CMD_CLEAR: begin
				for (int i = 0; i < CODES; i++)
					latch_mem[i] = 1'b0;
				rst_prev = 1'b0;
				aux_prev = 1'b0;
				sel_prev = 1'b0;
				mask_or = '0;
				worst_sev = alm_pkg::SEV_INFO;
				reset_ok = 1'b0;
				aux_ok = 1'b0;
			end
			alm_pkg::CMD_PREPARE: begin
				rst_rise = it.reset_level && !rst_prev;
				aux_rise = it.aux_level && !aux_prev;
				sel_rise = it.selective_level && !sel_prev;
				rst_prev = it.reset_level;
				aux_prev = it.aux_level;
				sel_prev = it.selective_level;
				mask_or = '0;
				worst_sev = alm_pkg::SEV_INFO;
				reset_ok = 1'b0;
				aux_ok = 1'b0;
			end
			alm_pkg::CMD_PROCESS: begin
				if (!code_ok) begin
					fault_flag = 1'b1;
				end else begin
					hold_for_reset = (it.severity <= alm_pkg::SEV_ANOMALY) &&
						(it.reset_policy != alm_pkg::POL_AUTO);
					auto_policy = (it.reset_policy == alm_pkg::POL_AUTO_COND) ||
						(it.reset_policy == alm_pkg::POL_AUTO_PROV) ||
						(it.reset_policy == alm_pkg::POL_AUTO_PRIO);
					// Set on activation; otherwise release when a clear path is open.
					if (it.activation) begin
						latch_mem[slot] = 1'b1;
					end else if (latch_mem[slot]) begin
						if (!hold_for_reset || rst_rise ||
							(aux_rise && it.reset_policy == alm_pkg::POL_AUX) ||
							(it.auto_condition && auto_policy) ||
							(sel_rise && it.selective_code == it.signal_code))
							latch_mem[slot] = 1'b0;
					end
					// A code that stays latched feeds the accumulators.
					if (latch_mem[slot]) begin
						mask_or = mask_or | it.action_bits;
						if (it.severity < worst_sev)
							worst_sev = it.severity;
						if (!it.activation && hold_for_reset)
							reset_ok = 1'b1;
						if (!it.activation && it.reset_policy == alm_pkg::POL_AUX)
							aux_ok = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		st.latched = code_ok ? latch_mem[slot] : 1'b0;
		st.action_mask = mask_or;
		st.worst_severity = worst_sev;
		st.reset_allowed = reset_ok;
		st.aux_allowed = aux_ok;
		st.fault = fault_flag;
		return st;
	endfunction

	function automatic alm_pkg::alm_item_t signal_item(logic [7:0] code, logic [1:0] sev,
		logic [2:0] pol, logic act, logic autoc, logic [15:0] bits);
		alm_pkg::alm_item_t it;
		it = '0;
		it.command = alm_pkg::CMD_PROCESS;
		it.signal_code = code;
		it.severity = sev;
		it.reset_policy = pol;
		it.activation = act;
		it.auto_condition = autoc;
		it.action_bits = bits;
		return it;
	endfunction

	function automatic alm_pkg::alm_item_t prepare_item(logic rst, logic aux, logic sel,
		logic [7:0] sel_code);
		alm_pkg::alm_item_t it;
		it = '0;
		it.command = alm_pkg::CMD_PREPARE;
		it.reset_level = rst;
		it.aux_level = aux;
		it.selective_level = sel;
		it.selective_code = sel_code;
		return it;
	endfunction

	task automatic log_failure(string msg);
		failures++;
		if (failures <= 10)
			$display("%0t ns: %s", $realtime, msg);
	endtask

	// Offer one item after a random gap and record its expected status on transfer.
	task automatic send_item(alm_pkg::alm_item_t it);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, STALL_MAX);
		repeat (gap) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		item_valid <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (item_stall);
		status_q.push_back(advance_alarm_state(it));
	endtask

	// Back-pressure on the result side, drawn anew for every result.
	initial begin
		int gap;
		result_stall = 1'b0;
		forever begin
			gap = no_gaps ? 0 : $urandom_range(0, STALL_MAX);
			repeat (gap) begin
				@(negedge clk);
				result_stall <= 1'b1;
			end
			@(negedge clk);
			result_stall <= 1'b0;
			do
				@(posedge clk);
			while (!(result_valid && !result_stall));
		end
	end

	// Compare every result transfer with the oldest expected status.
	always @(posedge clk) begin
		alm_pkg::alm_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (status_q.size() == 0) begin
				log_failure("result transfer with no status expected");
			end else begin
				want = status_q.pop_front();
				if (result.latched !== want.latched ||
					result.action_mask !== want.action_mask ||
					result.worst_severity !== want.worst_severity ||
					result.reset_allowed !== want.reset_allowed ||
					result.aux_allowed !== want.aux_allowed ||
					result.fault !== want.fault)
					log_failure($sformatf({"status mismatch (expected/actual): ",
						"latched %0b/%0b mask %h/%h severity %0d/%0d ",
						"reset %0b/%0b aux %0b/%0b fault %0b/%0b"},
						want.latched, result.latched, want.action_mask,
						result.action_mask, want.worst_severity, result.worst_severity,
						want.reset_allowed, result.reset_allowed, want.aux_allowed,
						result.aux_allowed, want.fault, result.fault));
			end
		end
	end

	// End the run if no transfer happens on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("alarm_latch_manager verification failed");
				$finish;
			end
		end
	end

	// Latch one code per policy, then try to release each of them with no edges captured.
	task automatic test_policy_release;
		logic [7:0] code;
		for (int p = 0; p < 8; p++) begin
			code = (p == 0) ? 8'd1 : 8'(57 + p);
			send_item(signal_item(code, 2'(p % 2), p[2:0], 1'b1, 1'b0,
				(p == 0) ? 16'hFFFF : 16'h0001 << (p + 8)));
		end
		send_item(prepare_item(1'b0, 1'b0, 1'b0, 8'd0));
		// Auto policies clear here; manual, aux and unlisted ones hold.
		for (int p = 0; p < 8; p++) begin
			code = (p == 0) ? 8'd1 : 8'(57 + p);
			send_item(signal_item(code, 2'(p % 2), p[2:0], 1'b0, 1'b1,
				16'h0001 << p));
		end
	endtask

	// Aux, selective and manual reset edges each open their own clear path.
	task automatic test_level_edges;
		send_item(prepare_item(1'b0, 1'b1, 1'b1, 8'd1));
		send_item(signal_item(8'd59, alm_pkg::SEV_ALARM, alm_pkg::POL_AUX, 1'b0, 1'b0,
			16'h00F0));
		send_item(signal_item(8'd1, alm_pkg::SEV_ALARM, alm_pkg::POL_MANUAL, 1'b0, 1'b0,
			16'h0F00));
		send_item(signal_item(8'd63, alm_pkg::SEV_ALARM, 3'd6, 1'b0, 1'b0, 16'h1234));
		// Only the manual reset level rises now.
		send_item(prepare_item(1'b1, 1'b1, 1'b1, 8'd1));
		send_item(signal_item(8'd63, alm_pkg::SEV_ALARM, 3'd6, 1'b0, 1'b0, 16'h4321));
	endtask

	// Out-of-range codes set the sticky fault, which clear-all leaves alone.
	task automatic test_bad_codes;
		alm_pkg::alm_item_t it;
		send_item(signal_item(8'd0, alm_pkg::SEV_ALARM, alm_pkg::POL_MANUAL, 1'b1, 1'b0,
			16'h0001));
		send_item(signal_item(8'd255, alm_pkg::SEV_INFO, 3'd7, 1'b1, 1'b1, 16'hFFFF));
		send_item(signal_item(8'(CODES + 1), alm_pkg::SEV_ALARM, alm_pkg::POL_MANUAL,
			1'b1, 1'b0, 16'h8000));
		it = '0;
		it.command = alm_pkg::CMD_NOP;
		it.signal_code = 8'd64;
		send_item(it);
		it.command = alm_pkg::CMD_CLEAR;
		send_item(it);
	endtask

	// Random command mix over a small code pool so latches are revisited often.
	task automatic test_random_traffic;
		logic [63:0]        raw;
		alm_pkg::alm_item_t it;
		int                 pick;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			raw = {$urandom(), $urandom()};
			it = raw[$bits(alm_pkg::alm_item_t)-1:0];
			pick = $urandom_range(0, 99);
			if (pick < 3)
				it.command = alm_pkg::CMD_CLEAR;
			else if (pick < 20)
				it.command = alm_pkg::CMD_PREPARE;
			else if (pick < 23)
				it.command = alm_pkg::CMD_NOP;
			else
				it.command = alm_pkg::CMD_PROCESS;
			pick = $urandom_range(0, 99);
			if (pick < 70)
				it.signal_code = 8'($urandom_range(1, 8));
			else if (pick < 88)
				it.signal_code = 8'($urandom_range(1, CODES));
			else if (pick < 92)
				it.signal_code = 8'd0;
			else
				it.signal_code = 8'($urandom_range(CODES + 1, 255));
			if ($urandom_range(0, 1))
				it.selective_code = 8'($urandom_range(1, 8));
			it.activation = ($urandom_range(0, 99) < 35);
			send_item(it);
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		for (int i = 0; i < CODES; i++)
			latch_mem[i] = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_policy_release();
		test_level_edges();
		test_bad_codes();
		test_random_traffic();

		@(negedge clk);
		item_valid <= 1'b0;
		while (status_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && status_q.size() == 0)
			$display("alarm_latch_manager verification clean");
		else
			$display("alarm_latch_manager verification failed");
		$finish;
	end

endmodule
